@@ rtl/ssfd_pkg.sv @@
// Package for the SysEx superframe deframer: framing constants, command
// codes, header table and the emit sequencer state type.
// No dependencies.
package ssfd_pkg;

    // Input commands
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Framing bytes
    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] END_BYTE   = 8'hF7;
    localparam logic [7:0] DATA_MASK  = 8'h7F;

    // Frame layout (positions within a frame)
    localparam logic [5:0] FRAME_LEN   = 6'd48;
    localparam logic [5:0] HDR_LEN     = 6'd5;
    localparam logic [5:0] PAYLOAD_END = 6'd47;

    // Emit sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Expected header byte at frame positions 0..4
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'hF0;
            3'd1:    b = 8'h7D;
            3'd2:    b = 8'h45;   // 'E'
            3'd3:    b = 8'h4D;   // 'M'
            3'd4:    b = 8'h57;   // 'W'
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/ssfd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 18
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sysex_superframe_deframer.sv @@
// SysEx superframe deframer top level: framing, header check, 7-bit unpack
// and lane emit. Depends on ssfd_pkg and ssfd_ram.
//
// Bytes (or restart commands) are taken one per cycle while no lane run is
// being emitted. A frame starts at F0, must carry the header F0 7D 'E' 'M' 'W'
// and end with F7 exactly at byte 48; its 7-bit payload is unpacked on the fly
// into a lane RAM of LANE_BYTES entries. When a frame with a nonzero lane is
// accepted, input stalls while the lane is played out: each beat is read
// from the RAM in ST_READ, then loaded into the output register in ST_LOAD,
// which waits while the output side holds off. The last beat may still wait
// in the output register while new bytes are already being accepted.
module sysex_superframe_deframer #(
    parameter int LANE_BYTES = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_byte_value,
    // lane output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_lane_byte,
    output logic [4:0] o_lane_index,
    output logic       o_last
);

    import ssfd_pkg::*;

    localparam int AW = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(LANE_BYTES - 1);
    localparam logic [5:0]    LANE_LEN = 6'(LANE_BYTES);

    // framing state
    logic [5:0] r_fill,    n_fill;
    logic       r_hdr_ok,  n_hdr_ok;
    logic [7:0] r_prefix,  n_prefix;
    logic       r_nonzero, n_nonzero;

    // emit sequencer
    t_state     r_state,   n_state;
    logic [AW-1:0] r_rd_idx, n_rd_idx;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_lane_byte;
    logic [4:0] r_lane_index;
    logic       r_last;
    logic       w_out_load;

    // datapath helpers
    logic       w_in_acc;
    logic       w_is_start;
    logic [5:0] w_fill_eff;
    logic [5:0] w_p;
    logic [2:0] w_pos;
    logic [2:0] w_grp;
    logic [5:0] w_d;
    logic [7:0] w_dec;
    logic       w_frame_ok;
    logic [5:0] w_idx_ext;

    // lane RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [7:0]    w_rdata;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_is_start = (i_byte_value == START_BYTE);

    // payload position decode
    assign w_fill_eff = w_is_start ? 6'd0 : r_fill;
    assign w_p        = w_fill_eff - HDR_LEN;
    assign w_pos      = w_p[2:0];
    assign w_grp      = w_p[5:3];
    assign w_d        = 6'(w_grp) * 6'd7 + 6'(w_pos) - 6'd1;
    assign w_dec      = (i_byte_value & DATA_MASK)
                      | {r_prefix[w_pos - 3'd1], 7'd0};

    // framing, header check and unpack
    always_comb begin
        n_fill     = r_fill;
        n_hdr_ok   = r_hdr_ok;
        n_prefix   = r_prefix;
        n_nonzero  = r_nonzero;
        w_we       = 1'b0;
        w_waddr    = w_d[AW-1:0];
        w_wdata    = w_dec;
        w_frame_ok = 1'b0;
        if (w_in_acc) begin
            if (i_command == CMD_RESTART) begin
                n_fill    = 6'd0;
                n_hdr_ok  = 1'b0;
                n_prefix  = 8'd0;
                n_nonzero = 1'b0;
            end else if (w_fill_eff == 6'd0 && !w_is_start) begin
                n_fill = 6'd0;                  // outside a frame: drop
            end else if (w_fill_eff >= FRAME_LEN) begin
                n_fill = 6'd0;                  // overlong frame: discard
            end else begin
                n_fill = w_fill_eff + 6'd1;
                if (w_fill_eff == 6'd0) begin
                    n_hdr_ok  = 1'b1;
                    n_nonzero = 1'b0;
                    n_prefix  = 8'd0;
                end else if (w_fill_eff < HDR_LEN) begin
                    if (i_byte_value != hdr_byte(w_fill_eff[2:0])) begin
                        n_hdr_ok = 1'b0;
                    end
                end else if (w_fill_eff < PAYLOAD_END) begin
                    if (w_pos == 3'd0) begin
                        n_prefix = i_byte_value;
                    end else if (w_d < LANE_LEN) begin
                        w_we = 1'b1;
                        if (w_dec != 8'd0) begin
                            n_nonzero = 1'b1;
                        end
                    end
                end
                if (i_byte_value == END_BYTE) begin
                    if (n_fill == FRAME_LEN && n_hdr_ok && n_nonzero) begin
                        w_frame_ok = 1'b1;
                    end
                    n_fill = 6'd0;
                end
            end
        end
    end

    // emit sequencer: read one lane entry, then load it into the output reg
    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        w_re       = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_frame_ok) begin
                    n_state  = ST_READ;
                    n_rd_idx = '0;
                end
            end
            ST_READ: begin
                w_re    = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 6'd0;
            r_hdr_ok    <= 1'b0;
            r_prefix    <= 8'd0;
            r_nonzero   <= 1'b0;
            r_state     <= ST_IDLE;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_hdr_ok    <= n_hdr_ok;
            r_prefix    <= n_prefix;
            r_nonzero   <= n_nonzero;
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    assign w_idx_ext = 6'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_lane_byte  <= w_rdata;
            r_lane_index <= w_idx_ext[4:0];
            r_last       <= (r_rd_idx == LAST_IDX);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lane_byte  = r_lane_byte;
    assign o_lane_index = r_lane_index;
    assign o_last       = r_last;

    // lane store
    ssfd_ram #(
        .WIDTH (8),
        .DEPTH (LANE_BYTES)
    ) u_lane_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

endmodule

@@ verif/sysex_superframe_deframer_tb.sv @@
// Self-checking testbench for sysex_superframe_deframer: directed frames from a stimulus
// table, then a random mix of good, broken and noisy superframes with random idling.
// Depends on ssfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
    import ssfd_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int LANE_N       = 18;
    localparam int DRAIN_CYCLES = 2 * LANE_N + 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RAND_ITEMS   = 30;

    typedef enum {
        FK_GOOD, FK_ZERO_LANE, FK_BAD_HDR, FK_EARLY_END, FK_OVERLONG,
        FK_CUT_RESTART, FK_CUT_START, FK_NOISE, FK_RESTART
    } t_frame_kind;

    // fill < 0: random payload; n_beats < 0: count not checked; beat_val < 0: value not checked
    typedef struct {
        t_frame_kind kind;
        int          fill;
        int          pos;
        int          n_beats;
        int          beat_val;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] lane_byte;
        logic [4:0] lane_index;
        logic       last;
    } t_lane_beat;

    localparam int N_ROWS = 10;
    t_stim_row stim_rows [N_ROWS] = '{
        '{FK_RESTART,     -1,    0,  0,  -1},    // restart straight out of reset
        '{FK_NOISE,       -1,    0,  0,  -1},    // bytes outside any frame
        '{FK_GOOD,        'hFF,  0, 18, 'hFF},   // all ones
        '{FK_GOOD,        'h80,  0,  0,  -1},    // only masked bits set: zero lane
        '{FK_ZERO_LANE,   -1,   17, 18,  -1},    // lone nonzero at the lane end
        '{FK_BAD_HDR,     -1,    4,  0,  -1},
        '{FK_EARLY_END,   -1,    3,  0,  -1},    // end byte inside the header
        '{FK_EARLY_END,   -1,   46,  0,  -1},    // end byte one short of the frame
        '{FK_CUT_START,   -1,   10,  0,  -1},    // start byte inside a frame
        '{FK_CUT_RESTART, -1,   12,  0,  -1}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic       i_command    = CMD_BYTE;
    logic [7:0] i_byte_value = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_lane_byte;
    logic [4:0] o_lane_index;
    logic       o_last;

    // Deframer image kept by the testbench
    int unsigned frame_fill   = 0;
    bit          frame_hdr_ok = 1'b0;
    logic [7:0]  grp_prefix   = 8'h00;
    logic [7:0]  lane_img [LANE_N] = '{default: 8'h00};
    bit          lane_any     = 1'b0;
    t_lane_beat  lane_beats_due [$];

    int tx_idle_pct = 15;
    int rx_idle_pct = 20;
    int hold_cycles = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int beats_seen  = 0;
    int row_seen    = 0;
    int row_off     = 0;
    int row_val     = -1;
    int items_in    = 0;
    int frames_ok   = 0;

    sysex_superframe_deframer #(
        .LANE_BYTES(LANE_N)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_lane_byte  (o_lane_byte),
        .o_lane_index (o_lane_index),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Track one accepted beat; queue the lane run when a frame is accepted.
    // Returns 0 for a byte dropped outside any frame.
    function automatic bit deframe_predict(input logic cmd, input logic [7:0] b);
        int unsigned idx;
        int unsigned p;
        int unsigned d;
        logic [7:0]  dec;
        t_lane_beat  beat;
        if (cmd == CMD_RESTART) begin
            frame_fill   = 0;
            frame_hdr_ok = 1'b0;
            grp_prefix   = 8'h00;
            lane_any     = 1'b0;
            return 1'b1;
        end
        if (b == START_BYTE)
            frame_fill = 0;
        if (frame_fill == 0 && b != START_BYTE)
            return 1'b0;
        // overlong frame: this byte discards it
        if (frame_fill >= 48) begin
            frame_fill = 0;
            return 1'b1;
        end
        idx = frame_fill;
        frame_fill++;
        if (idx == 0) begin
            frame_hdr_ok = 1'b1;
            lane_any     = 1'b0;
            grp_prefix   = 8'h00;
        end else if (idx < 5) begin
            if (b != hdr_byte(3'(idx)))
                frame_hdr_ok = 1'b0;
        end else if (idx < 47) begin
            // groups of eight: prefix carries bit 7 of the next seven bytes
            p = idx - 5;
            if ((p & 7) == 0) begin
                grp_prefix = b;
            end else begin
                d = (p >> 3) * 7 + (p & 7) - 1;
                if (d < LANE_N) begin
                    dec = {grp_prefix[(p & 7) - 1], b[6:0]};
                    lane_img[d] = dec;
                    if (dec != 8'h00)
                        lane_any = 1'b1;
                end
            end
        end
        if (b == END_BYTE) begin
            if (frame_fill == 48 && frame_hdr_ok && lane_any) begin
                for (int i = 0; i < LANE_N; i++) begin
                    beat.lane_byte  = lane_img[i];
                    beat.lane_index = 5'(i);
                    beat.last       = (i == LANE_N - 1);
                    lane_beats_due.push_back(beat);
                end
                frames_ok++;
            end
            frame_fill = 0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == START_BYTE || v == END_BYTE);
        return v;
    endfunction

    function automatic logic [7:0] any_but_start();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == START_BYTE);
        return v;
    endfunction

    // One input beat, with an optional idle gap before it
    task automatic drive_beat(input logic cmd, input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_byte_value <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (deframe_predict(cmd, b))
            items_in++;
    endtask

    // Build a superframe, break it as the kind says, and send it
    task automatic run_frame(input t_frame_kind kind, input int fill, input int pos);
        logic [7:0] f [$];
        int         n_send;
        int         k;
        for (k = 0; k < 5; k++)
            f.push_back(hdr_byte(3'(k)));
        for (k = 0; k < 42; k++)
            f.push_back(fill < 0 ? body_byte() : 8'(fill));
        f.push_back(END_BYTE);
        n_send = f.size();
        case (kind)
            FK_ZERO_LANE: begin
                // payload bytes 0..20 carry the whole lane
                for (k = 5; k < 26; k++)
                    f[k] = 8'h00;
                if (pos >= 0)
                    f[5 + (pos / 7) * 8 + pos % 7 + 1] = 8'h01;
            end
            FK_BAD_HDR: f[pos] = f[pos] ^ (8'h01 << $urandom_range(6));
            FK_EARLY_END: begin
                f[pos] = END_BYTE;
                n_send = pos + 1;
            end
            FK_OVERLONG: begin
                f[47] = body_byte();
                repeat ($urandom_range(3, 1)) f.push_back(any_but_start());
                n_send = f.size();
            end
            FK_CUT_RESTART, FK_CUT_START: n_send = pos;
            FK_NOISE: begin
                f.delete();
                repeat ($urandom_range(4, 1)) f.push_back(any_but_start());
                n_send = f.size();
            end
            FK_RESTART: n_send = 0;
            default: ;
        endcase
        for (k = 0; k < n_send; k++)
            drive_beat(CMD_BYTE, f[k]);
        if (kind == FK_CUT_RESTART || kind == FK_RESTART)
            drive_beat(CMD_RESTART, 8'($urandom_range(255)));
        // leftover bytes after a restart must be dropped
        if (kind == FK_CUT_RESTART)
            for (k = pos; k < f.size() && k < pos + 3; k++)
                drive_beat(CMD_BYTE, f[k]);
    endtask

    // Wait until every queued lane beat has come out, then a margin
    task automatic settle();
        i_in_valid <= 1'b0;
        while (lane_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin : ready_gen
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Lane beat checker
    always @(posedge i_clk) begin : lane_monitor
        t_lane_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            row_seen++;
            if (row_val >= 0 && o_lane_byte != 8'(row_val))
                row_off++;
            if (lane_beats_due.size() == 0) begin
                note_error($sformatf("lane beat with nothing outstanding: byte %02h index %0d",
                                     o_lane_byte, o_lane_index));
            end else begin
                want = lane_beats_due.pop_front();
                if (o_lane_byte !== want.lane_byte)
                    note_error($sformatf("lane_byte: expected %02h, got %02h",
                                         want.lane_byte, o_lane_byte));
                if (o_lane_index !== want.lane_index)
                    note_error($sformatf("lane_index: expected %0d, got %0d",
                                         want.lane_index, o_lane_index));
                if (o_last !== want.last)
                    note_error($sformatf("last: expected %0b, got %0b", want.last, o_last));
            end
        end
    end

    // Main sequence
    initial begin
        int          r;
        int          seq;
        int          pick;
        int          items0;
        t_frame_kind kind;
        int          pos;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; the first full frames run with no idling on either side
        for (r = 0; r < N_ROWS; r++) begin
            if (r == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (r == 5) begin
                tx_idle_pct = 15;
                rx_idle_pct = 20;
            end
            row_seen = 0;
            row_off  = 0;
            row_val  = stim_rows[r].beat_val;
            run_frame(stim_rows[r].kind, stim_rows[r].fill, stim_rows[r].pos);
            settle();
            if (stim_rows[r].n_beats >= 0 && row_seen != stim_rows[r].n_beats)
                note_error($sformatf("row %0d: expected %0d lane beats, got %0d",
                                     r, stim_rows[r].n_beats, row_seen));
            if (row_off != 0)
                note_error($sformatf("row %0d: %0d lane beats differ from %02h",
                                     r, row_off, stim_rows[r].beat_val));
        end
        row_val = -1;

        // Output held off while bytes keep coming: input must back up
        hold_cycles = 300;
        run_frame(FK_GOOD, -1, 0);
        run_frame(FK_NOISE, -1, 0);
        settle();

        // Random mix, mostly well-formed frames
        items0 = items_in;
        seq    = 0;
        while (items_in - items0 < RAND_ITEMS) begin
            pick = $urandom_range(99);
            pos  = 0;
            if (pick < 55) begin
                kind = FK_GOOD;
            end else if (pick < 62) begin
                kind = FK_ZERO_LANE;
                pos  = $urandom_range(1) ? -1 : int'($urandom_range(LANE_N - 1));
            end else if (pick < 69) begin
                kind = FK_BAD_HDR;
                pos  = $urandom_range(4, 1);
            end else if (pick < 76) begin
                kind = FK_EARLY_END;
                pos  = $urandom_range(46, 1);
            end else if (pick < 82) begin
                kind = FK_OVERLONG;
            end else if (pick < 88) begin
                kind = FK_CUT_RESTART;
                pos  = $urandom_range(47, 1);
            end else if (pick < 94) begin
                kind = FK_CUT_START;
                pos  = $urandom_range(47, 1);
            end else if (pick < 97) begin
                kind = FK_NOISE;
            end else begin
                kind = FK_RESTART;
            end
            run_frame(kind, -1, pos);
            seq++;
        end
        settle();

        $display("Covered %0d directed rows, an output hold-off and %0d random sequences.",
                 N_ROWS, seq);
        $display("%0d input beats used, %0d frames accepted, %0d lane beats checked.",
                 items_in, frames_ok, beats_seen);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
